@@ rtl/nte_pkg.sv @@
package nte_pkg;

  // Field widths
  localparam int TEMPO_W  = 10;
  localparam int LEN_W    = 8;
  localparam int CNT_W    = 3;
  localparam int TONE_W   = 9;
  localparam int PERIOD_W = 17;
  localparam int DUR_W    = 28;
  localparam int SLICE_W  = 20;
  localparam int BASE_W   = 18;

  localparam int MAX_TONES = 4;
  localparam int SEL_W     = $clog2(MAX_TONES);
  localparam int MAX_RUN   = 64;
  localparam int RUN_W     = $clog2(MAX_RUN + 1);

  localparam logic [DUR_W-1:0]   WHOLE_NOTE_US = DUR_W'(240000000);
  localparam logic [SLICE_W-1:0] SLICE_RESET   = SLICE_W'(35000);
  localparam logic [TEMPO_W-1:0] TEMPO_RESET   = TEMPO_W'(120);

  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS = DUR_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Accidental codes
  localparam logic [1:0] ACC_NATURAL = 2'd0;
  localparam logic [1:0] ACC_SHARP   = 2'd1;
  localparam logic [1:0] ACC_FLAT    = 2'd2;

  // Micro-operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
  localparam logic [OP_W-1:0] OP_MUL        = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV        = 4'd2;
  localparam logic [OP_W-1:0] OP_SET_DUR    = 4'd3;
  localparam logic [OP_W-1:0] OP_LOAD_SLICE = 4'd4;
  localparam logic [OP_W-1:0] OP_SET_RUNS   = 4'd5;
  localparam logic [OP_W-1:0] OP_EMIT_REST  = 4'd6;
  localparam logic [OP_W-1:0] OP_EMIT_ERR   = 4'd7;
  localparam logic [OP_W-1:0] OP_EMIT_ONE   = 4'd8;
  localparam logic [OP_W-1:0] OP_EMIT_CHORD = 4'd9;

  // Jump conditions
  localparam int CND_W = 4;
  localparam logic [CND_W-1:0] C_NEVER     = 4'd0;
  localparam logic [CND_W-1:0] C_ALWAYS    = 4'd1;
  localparam logic [CND_W-1:0] C_NO_START  = 4'd2;
  localparam logic [CND_W-1:0] C_DIV_BUSY  = 4'd3;
  localparam logic [CND_W-1:0] C_REST      = 4'd4;
  localparam logic [CND_W-1:0] C_ERR       = 4'd5;
  localparam logic [CND_W-1:0] C_SINGLE    = 4'd6;
  localparam logic [CND_W-1:0] C_RUNS_ZERO = 4'd7;
  localparam logic [CND_W-1:0] C_MORE      = 4'd8;

  // Program steps
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] S_MUL       = 4'd1;
  localparam logic [PC_W-1:0] S_DIV_DUR   = 4'd2;
  localparam logic [PC_W-1:0] S_DUR       = 4'd3;
  localparam logic [PC_W-1:0] S_CHK_ERR   = 4'd4;
  localparam logic [PC_W-1:0] S_CHK_ONE   = 4'd5;
  localparam logic [PC_W-1:0] S_LOAD_SLC  = 4'd6;
  localparam logic [PC_W-1:0] S_DIV_RUNS  = 4'd7;
  localparam logic [PC_W-1:0] S_RUNS      = 4'd8;
  localparam logic [PC_W-1:0] S_EMIT_REST = 4'd9;
  localparam logic [PC_W-1:0] S_EMIT_ERR  = 4'd10;
  localparam logic [PC_W-1:0] S_EMIT_ONE  = 4'd11;
  localparam logic [PC_W-1:0] S_CHK_RUNS  = 4'd12;
  localparam logic [PC_W-1:0] S_EMIT_CHRD = 4'd13;
  localparam logic [PC_W-1:0] S_DONE      = 4'd14;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cond;
    logic [PC_W-1:0]  target;
  } nte_uword_t;

  typedef struct packed {
    logic load;
    logic step;
  } nte_div_ctl_t;

  typedef struct packed {
    logic                ok;
    logic [PERIOD_W-1:0] period;
  } nte_tone_t;

  // Microprogram
  function automatic nte_uword_t ucode(input logic [PC_W-1:0] pc);
    nte_uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    unique case (pc)
      S_IDLE:      w = '{op: OP_NOP,        cond: C_NO_START,  target: S_IDLE};
      S_MUL:       w = '{op: OP_MUL,        cond: C_NEVER,     target: S_IDLE};
      S_DIV_DUR:   w = '{op: OP_DIV,        cond: C_DIV_BUSY,  target: S_DIV_DUR};
      S_DUR:       w = '{op: OP_SET_DUR,    cond: C_REST,      target: S_EMIT_REST};
      S_CHK_ERR:   w = '{op: OP_NOP,        cond: C_ERR,       target: S_EMIT_ERR};
      S_CHK_ONE:   w = '{op: OP_NOP,        cond: C_SINGLE,    target: S_EMIT_ONE};
      S_LOAD_SLC:  w = '{op: OP_LOAD_SLICE, cond: C_NEVER,     target: S_IDLE};
      S_DIV_RUNS:  w = '{op: OP_DIV,        cond: C_DIV_BUSY,  target: S_DIV_RUNS};
      S_RUNS:      w = '{op: OP_SET_RUNS,   cond: C_ALWAYS,    target: S_CHK_RUNS};
      S_EMIT_REST: w = '{op: OP_EMIT_REST,  cond: C_ALWAYS,    target: S_IDLE};
      S_EMIT_ERR:  w = '{op: OP_EMIT_ERR,   cond: C_ALWAYS,    target: S_IDLE};
      S_EMIT_ONE:  w = '{op: OP_EMIT_ONE,   cond: C_ALWAYS,    target: S_IDLE};
      S_CHK_RUNS:  w = '{op: OP_NOP,        cond: C_RUNS_ZERO, target: S_IDLE};
      S_EMIT_CHRD: w = '{op: OP_EMIT_CHORD, cond: C_MORE,      target: S_EMIT_CHRD};
      S_DONE:      w = '{op: OP_NOP,        cond: C_ALWAYS,    target: S_IDLE};
      default:     w = '{op: OP_NOP,        cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] letter_semitone(input logic [2:0] letter);
    logic [3:0] s;
    case (letter)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd2;
      3'd2:    s = 4'd4;
      3'd3:    s = 4'd5;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd9;
      3'd6:    s = 4'd11;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // Divider for octave -1, one entry per semitone
  function automatic logic [BASE_W-1:0] octave_base(input logic [3:0] k);
    logic [BASE_W-1:0] b;
    case (k)
      4'd0:    b = BASE_W'(145940);
      4'd1:    b = BASE_W'(137749);
      4'd2:    b = BASE_W'(130018);
      4'd3:    b = BASE_W'(122720);
      4'd4:    b = BASE_W'(115833);
      4'd5:    b = BASE_W'(109331);
      4'd6:    b = BASE_W'(103195);
      4'd7:    b = BASE_W'(97403);
      4'd8:    b = BASE_W'(91936);
      4'd9:    b = BASE_W'(86776);
      4'd10:   b = BASE_W'(81906);
      4'd11:   b = BASE_W'(77309);
      default: b = '0;
    endcase
    return b;
  endfunction

  // Pitch to timer divider; semitone and octave carried past the octave edge
  function automatic nte_tone_t decode_tone(input logic [TONE_W-1:0] code);
    nte_tone_t  t;
    logic [2:0] letter;
    logic [3:0] octave;
    logic [1:0] acc;
    logic [3:0] semi;
    logic [3:0] k;
    logic [3:0] shift;
    letter = code[2:0];
    octave = code[6:3];
    acc    = code[8:7];
    semi   = letter_semitone(letter);
    t.ok   = (letter != 3'd7) && (octave <= 4'd9) && (acc != 2'd3);
    if (acc == ACC_FLAT && semi == 4'd0) begin
      k     = 4'd11;
      shift = octave;
    end else if (acc == ACC_SHARP && semi == 4'd11) begin
      k     = 4'd0;
      shift = octave + 4'd2;
    end else begin
      if (acc == ACC_SHARP) begin
        k = semi + 4'd1;
      end else if (acc == ACC_FLAT) begin
        k = semi - 4'd1;
      end else begin
        k = semi;
      end
      shift = octave + 4'd1;
    end
    t.period = t.ok ? PERIOD_W'(octave_base(k) >> shift) : '0;
    return t;
  endfunction

endpackage

@@ rtl/nte_event_if.sv @@
interface nte_event_if
  import nte_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                command;
  logic [TEMPO_W-1:0]  tempo_bpm;
  logic                is_rest;
  logic [LEN_W-1:0]    length_div;
  logic [CNT_W-1:0]    tone_count;
  logic [TONE_W-1:0]   tone_0;
  logic [TONE_W-1:0]   tone_1;
  logic [TONE_W-1:0]   tone_2;
  logic [TONE_W-1:0]   tone_3;

  modport source (
    output valid, command, tempo_bpm, is_rest, length_div, tone_count,
           tone_0, tone_1, tone_2, tone_3,
    input  ready
  );
  modport sink (
    input  valid, command, tempo_bpm, is_rest, length_div, tone_count,
           tone_0, tone_1, tone_2, tone_3,
    output ready
  );
endinterface

@@ rtl/nte_cmd_if.sv @@
interface nte_cmd_if
  import nte_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] tone_period;
  logic [DUR_W-1:0]    duration_us;
  logic                last;
  logic                note_error;

  modport source (
    output valid, tone_period, duration_us, last, note_error,
    input  ready
  );
  modport sink (
    input  valid, tone_period, duration_us, last, note_error,
    output ready
  );
endinterface

@@ rtl/nte_divider.sv @@
module nte_divider
  import nte_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  nte_div_ctl_t     ctl,
  input  logic [DUR_W-1:0] dividend,
  input  logic [DUR_W-1:0] divisor,
  output logic [DUR_W-1:0] quotient,
  output logic             busy
);

  logic [DUR_W-1:0]  rem;
  logic [DUR_W-1:0]  quo;
  logic [DUR_W-1:0]  dvs;
  logic [DCNT_W-1:0] cnt;
  logic [DUR_W:0]    trial;
  logic [DUR_W:0]    diff;

  // Shift in the next dividend bit and try to subtract
  assign trial = {rem, quo[DUR_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= '0;
    end else if (ctl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (ctl.step) begin
      if (!diff[DUR_W]) begin
        rem <= diff[DUR_W-1:0];
        quo <= {quo[DUR_W-2:0], 1'b1};
      end else begin
        rem <= trial[DUR_W-1:0];
        quo <= {quo[DUR_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
  assign busy     = cnt != DCNT_W'(DIV_STEPS - 1);

endmodule

@@ rtl/note_event_to_tone_commands_top.sv @@
// Note event to tone command converter.
//
// note_in is a valid/ready channel of note events. A set-tempo event
// (command 0) stores the tempo and produces nothing. A play event
// (command 1) produces tone commands on tone_out: a rest, a single tone,
// an error marker for a bad tone code, or a chord played as a run of
// slices of chord_slice_us each, at most 64. The final command of an event
// carries last. The user must write chord_slice_us through cfg_wr_en and
// cfg_wr_data while the block is idle; the block does not enforce this.
//
// One event is handled at a time. A microcoded sequencer walks a 15-step
// program; the cost is set by a shared restoring divider that yields one
// quotient bit per cycle. A chord emits one slice per cycle while the
// receiver does not stall. A set-tempo event leaves the sequencer idle.
//
// tone_out is driven from an output register. When the receiver stalls,
// the sequencer holds on its emit step until the register drains.
// Reset clears the tempo to 120, the slice length to 35000 us, the program
// counter to idle and the output register to empty.
module note_event_to_tone_commands_top
  import nte_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [SLICE_W-1:0]  cfg_wr_data,
  nte_event_if.sink           note_in,
  nte_cmd_if.source           tone_out
);

  // Sequencer
  logic [PC_W-1:0] pc;
  nte_uword_t      uw;
  logic            cond_true;
  logic            hold;
  logic            is_emit;

  // Stored state
  logic [TEMPO_W-1:0] tempo;
  logic [SLICE_W-1:0] chord_slice_us;

  // Captured event
  logic [LEN_W-1:0]                  length;
  logic                              rest;
  logic [CNT_W-1:0]                  cnt;
  logic [MAX_TONES-1:0][PERIOD_W-1:0] periods;
  logic                              bad_tone;

  // Working registers
  logic              zero_div;
  logic [DUR_W-1:0]  dur;
  logic [RUN_W-1:0]  runs;
  logic [RUN_W-1:0]  idx;
  logic [SEL_W-1:0]  sel;

  // Output register
  logic                out_valid;
  logic [PERIOD_W-1:0] out_period;
  logic [DUR_W-1:0]    out_dur;
  logic                out_last;
  logic                out_err;

  // Divider port
  nte_div_ctl_t     div_ctl;
  logic [DUR_W-1:0] div_dividend;
  logic [DUR_W-1:0] div_divisor;
  logic [DUR_W-1:0] div_quo;
  logic             div_busy;

  logic                              in_xfer;
  logic                              start;
  logic [CNT_W-1:0]                  cnt_in;
  logic [MAX_TONES-1:0][TONE_W-1:0]  tones_in;
  nte_tone_t [MAX_TONES-1:0]         dec;
  logic                              bad_in;
  logic [SLICE_W-1:0]                slice_eff;
  logic [LEN_W+TEMPO_W-1:0]          product;
  logic                              more;

  assign note_in.ready = (pc == S_IDLE);
  assign in_xfer       = note_in.valid && note_in.ready;
  assign start         = in_xfer && note_in.command;

  assign uw      = ucode(pc);
  assign is_emit = (uw.op == OP_EMIT_REST) || (uw.op == OP_EMIT_ERR) ||
                   (uw.op == OP_EMIT_ONE)  || (uw.op == OP_EMIT_CHORD);
  // Hold the emit step while the output register is full and not draining
  assign hold    = is_emit && out_valid && !tone_out.ready;

  assign slice_eff = (chord_slice_us == '0) ? SLICE_W'(1) : chord_slice_us;
  assign product   = length * tempo;
  assign more      = (idx + 1'b1) != runs;

  // Clamp the tone count to 1..MAX_TONES and decode every tone in parallel
  always_comb begin
    tones_in = {note_in.tone_3, note_in.tone_2, note_in.tone_1, note_in.tone_0};
    if (note_in.tone_count == '0) begin
      cnt_in = CNT_W'(1);
    end else if (note_in.tone_count > CNT_W'(MAX_TONES)) begin
      cnt_in = CNT_W'(MAX_TONES);
    end else begin
      cnt_in = note_in.tone_count;
    end
    bad_in = 1'b0;
    for (int i = 0; i < MAX_TONES; i++) begin
      dec[i] = decode_tone(tones_in[i]);
      if (CNT_W'(i) < cnt_in && !dec[i].ok) begin
        bad_in = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NO_START:  cond_true = !start;
      C_DIV_BUSY:  cond_true = div_busy;
      C_REST:      cond_true = rest;
      C_ERR:       cond_true = bad_tone;
      C_SINGLE:    cond_true = (cnt == CNT_W'(1));
      C_RUNS_ZERO: cond_true = (runs == '0);
      C_MORE:      cond_true = more;
      default:     cond_true = 1'b0;
    endcase
  end

  // Drive the divider from the current micro-operation
  always_comb begin
    div_ctl      = '{load: 1'b0, step: 1'b0};
    div_dividend = WHOLE_NOTE_US;
    div_divisor  = DUR_W'(product);
    unique case (uw.op)
      OP_MUL: begin
        div_ctl.load = 1'b1;
      end
      OP_LOAD_SLICE: begin
        div_ctl.load = 1'b1;
        div_dividend = dur;
        div_divisor  = DUR_W'(slice_eff);
      end
      OP_DIV: begin
        div_ctl.step = 1'b1;
      end
      default: begin
      end
    endcase
  end

  nte_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .busy     (div_busy)
  );

  // Step counter: advance, jump when the condition holds, hold on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else if (!hold) begin
      pc <= cond_true ? uw.target : pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo          <= TEMPO_RESET;
      chord_slice_us <= SLICE_RESET;
    end else begin
      if (cfg_wr_en) begin
        chord_slice_us <= cfg_wr_data;
      end
      if (in_xfer && !note_in.command) begin
        tempo <= note_in.tempo_bpm;
      end
    end
  end

  // Capture the event on its transfer
  always_ff @(posedge clk) begin
    if (start) begin
      length   <= note_in.length_div;
      rest     <= note_in.is_rest;
      cnt      <= cnt_in;
      bad_tone <= bad_in;
      for (int i = 0; i < MAX_TONES; i++) begin
        periods[i] <= dec[i].period;
      end
    end
  end

  // Datapath micro-operations
  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_MUL: begin
        zero_div <= (product == '0);
      end
      OP_SET_DUR: begin
        dur <= zero_div ? WHOLE_NOTE_US : div_quo;
      end
      OP_SET_RUNS: begin
        runs <= (div_quo > DUR_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : div_quo[RUN_W-1:0];
        idx  <= '0;
        sel  <= '0;
      end
      OP_EMIT_CHORD: begin
        if (!hold) begin
          idx <= idx + 1'b1;
          if (({1'b0, sel} + 1'b1) == cnt) begin
            sel <= '0;
          end else begin
            sel <= sel + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load on an emit step, drop on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_emit && !hold) begin
      out_valid <= 1'b1;
    end else if (tone_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit && !hold) begin
      case (uw.op)
        OP_EMIT_REST: begin
          out_period <= '0;
          out_dur    <= dur;
          out_last   <= 1'b1;
          out_err    <= 1'b0;
        end
        OP_EMIT_ERR: begin
          out_period <= '0;
          out_dur    <= '0;
          out_last   <= 1'b1;
          out_err    <= 1'b1;
        end
        OP_EMIT_ONE: begin
          out_period <= periods[0];
          out_dur    <= dur;
          out_last   <= 1'b1;
          out_err    <= 1'b0;
        end
        default: begin
          out_period <= periods[sel];
          out_dur    <= DUR_W'(slice_eff);
          out_last   <= !more;
          out_err    <= 1'b0;
        end
      endcase
    end
  end

  assign tone_out.valid       = out_valid;
  assign tone_out.tone_period = out_period;
  assign tone_out.duration_us = out_dur;
  assign tone_out.last        = out_last;
  assign tone_out.note_error  = out_err;

endmodule
